[rtl/core/mgr_pkg.sv]
// Shared types, constants and helpers for the gray morphological range block.
package mgr_pkg;

    // Configuration register indexes (word-aligned, paddr[2] selects)
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [10:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    // Gray conversion weights, Q14
    localparam logic [22:0] COEF_B    = 23'd1868;
    localparam logic [22:0] COEF_G    = 23'd9617;
    localparam logic [22:0] COEF_R    = 23'd4899;
    localparam logic [22:0] GRAY_BIAS = 23'd8192;

    // Result queue geometry
    localparam int QDEPTH = 8;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // One result transaction
    typedef struct packed {
        logic [9:0]  mirror_column;
        logic [11:0] out_row;
        logic [7:0]  range_value;
        logic        run_last;
        logic        frame_last;
    } t_result;

    // Push strobes into the result queue; second is only set together with first
    typedef struct packed {
        logic first;
        logic second;
    } t_push;

    function automatic logic [7:0] gray_of(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
        logic [22:0] s;
        s = 23'(b) * COEF_B + 23'(g) * COEF_G + 23'(r) * COEF_R + GRAY_BIAS;
        return s[21:14];
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(max2(a, b), c);
    endfunction

    function automatic logic [7:0] min3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return min2(min2(a, b), c);
    endfunction

endpackage

[rtl/core/mgr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module mgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/mgr_ofifo.sv]
// Result queue: takes up to two results per cycle, hands out one per transaction.
module mgr_ofifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mgr_pkg::t_push                i_push,
    input  mgr_pkg::t_result              i_first,
    input  mgr_pkg::t_result              i_second,
    input  logic                          i_pop,
    output logic                          o_valid,
    output mgr_pkg::t_result              o_head,
    output logic [mgr_pkg::CNT_W-1:0]     o_count
);

    mgr_pkg::t_result                r_q [mgr_pkg::QDEPTH];
    logic [mgr_pkg::PTR_W-1:0]       r_wptr, n_wptr;
    logic [mgr_pkg::PTR_W-1:0]       r_rptr, n_rptr;
    logic [mgr_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            w_pop;
    logic [mgr_pkg::PTR_W-1:0]       w_wptr1;

    assign w_pop   = i_pop && (r_count != '0);
    assign w_wptr1 = mgr_pkg::PTR_W'(r_wptr + 1'b1);

    // Pointer and fill bookkeeping
    always_comb begin
        n_wptr  = mgr_pkg::PTR_W'(r_wptr + mgr_pkg::PTR_W'(i_push.first)
                                         + mgr_pkg::PTR_W'(i_push.second));
        n_rptr  = mgr_pkg::PTR_W'(r_rptr + mgr_pkg::PTR_W'(w_pop));
        n_count = mgr_pkg::CNT_W'(r_count + mgr_pkg::CNT_W'(i_push.first)
                                          + mgr_pkg::CNT_W'(i_push.second)
                                          - mgr_pkg::CNT_W'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Entry storage; the pair lands in consecutive slots
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_q[r_wptr] <= i_first;
        end
        if (i_push.second) begin
            r_q[w_wptr1] <= i_second;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_head  = r_q[r_rptr];
    assign o_count = r_count;

endmodule

[rtl/core/mirrored_gray_morph_range_3x3.sv]
// Top level: BGR stream to 3x3 gray max-minus-min with mirrored column tags.
// Takes one BGR pixel per clock in raster order, converts it to 8-bit gray and
// reports the 3x3 max minus min with replicate borders, one row and one pixel
// behind the input; after each frame send one row of frame_width filler pixels
// to flush the last row. The last pixel of each row yields two results, column
// zero yields none, so a row in averages one result per clock. Input rate is
// one pixel per cycle, set by the line buffers, which take one read and one
// write-back per pixel, and the window update; results enter an 8-entry queue
// straight from stage 2, and the input stalls only when the result side
// backs up and that queue can no longer take the results of pixels in flight.
// Line buffers need no clearing: every entry that reaches a result is written
// earlier in the same frame. Any register write restarts the frame at row zero,
// column zero.
module mirrored_gray_morph_range_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_blue,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_red,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [9:0]  o_mirror_column,
    output logic [11:0] o_out_row,
    output logic [7:0]  o_range_value,
    output logic        o_run_last,
    output logic        o_frame_last,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

    // Configuration registers
    logic [10:0] r_frame_width;
    logic [11:0] r_frame_height;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mgr_pkg::FRAME_WIDTH_RST;
            r_frame_height <= mgr_pkg::FRAME_HEIGHT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                mgr_pkg::REG_FRAME_WIDTH:  r_frame_width  <= pwdata[10:0];
                mgr_pkg::REG_FRAME_HEIGHT: r_frame_height <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            mgr_pkg::REG_FRAME_WIDTH:  prdata = {21'd0, r_frame_width};
            mgr_pkg::REG_FRAME_HEIGHT: prdata = {20'd0, r_frame_height};
            default:                   prdata = '0;
        endcase
    end

    // Saturated frame geometry
    logic [WW-1:0] w_width;
    logic [11:0]   w_height;

    always_comb begin
        if (r_frame_width < 11'd2) begin
            w_width = WW'(2);
        end else if (WW'(r_frame_width) > WW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = WW'(r_frame_width);
        end
        w_height = (r_frame_height < 12'd2) ? 12'd2 : r_frame_height;
    end

    // Input position counters
    logic [CW-1:0] r_col, n_col, w_col;
    logic [11:0]   r_row, n_row, w_row;
    logic          w_accept;
    logic          w_tail;
    logic [1:0]    w_nres;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        if ((WW'(r_col) >= w_width) || (r_row > w_height)) begin
            w_col = '0;
            w_row = '0;
        end else begin
            w_col = r_col;
            w_row = r_row;
        end
        w_tail = (WW'(w_col) == WW'(w_width - 1'b1));
        if (w_tail) begin
            n_col = '0;
            n_row = (w_row == w_height) ? 12'd0 : 12'(w_row + 1'b1);
        end else begin
            n_col = CW'(w_col + 1'b1);
            n_row = w_row;
        end
        if ((w_row == 12'd0) || (w_col == '0)) begin
            w_nres = 2'd0;
        end else begin
            w_nres = w_tail ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1: pixel and position, line buffer data arrives
    logic          r_s1_valid;
    logic [1:0]    r_s1_nres;
    logic [CW-1:0] r_s1_col;
    logic [11:0]   r_s1_row;
    logic [7:0]    r_s1_blue, r_s1_green, r_s1_red;
    logic          r_s1_top_row, r_s1_last_row, r_s1_we, r_s1_first_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_nres  <= 2'd0;
        end else begin
            r_s1_valid <= w_accept;
            r_s1_nres  <= w_accept ? w_nres : 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_col       <= w_col;
            r_s1_row       <= w_row;
            r_s1_blue      <= i_blue;
            r_s1_green     <= i_green;
            r_s1_red       <= i_red;
            r_s1_top_row   <= (w_row <= 12'd1);
            r_s1_last_row  <= (w_row == w_height);
            r_s1_we        <= (w_row < w_height);
            r_s1_first_col <= (w_col == CW'(1));
        end
    end

    // Line buffers: read at accept, written back from stage 1 in the next cycle
    logic [7:0] w_upper_rd, w_middle_rd;
    logic [7:0] w_gray, w_top, w_bot;
    logic       w_line_we;

    assign w_line_we = r_s1_valid && r_s1_we;
    assign w_gray    = mgr_pkg::gray_of(r_s1_blue, r_s1_green, r_s1_red);
    assign w_top     = r_s1_top_row ? w_middle_rd : w_upper_rd;
    assign w_bot     = r_s1_last_row ? w_middle_rd : w_gray;

    mgr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_s1_col),
        .i_wdata (w_middle_rd),
        .i_raddr (w_col),
        .o_rdata (w_upper_rd)
    );

    mgr_ram #(
        .WIDTH (8),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (r_s1_col),
        .i_wdata (w_gray),
        .i_raddr (w_col),
        .o_rdata (w_middle_rd)
    );

    // Stage 2: 3x3 window, oldest column at index 0..2
    logic [7:0]    r_win [9];
    logic [1:0]    r_s2_nres;
    logic [CW-1:0] r_s2_col;
    logic [11:0]   r_s2_row;
    logic          r_s2_last_row, r_s2_first_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_nres <= 2'd0;
        end else begin
            r_s2_nres <= r_s1_nres;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= r_win[k + 3];
            end
            r_win[6]       <= w_top;
            r_win[7]       <= w_middle_rd;
            r_win[8]       <= w_bot;
            r_s2_col       <= r_s1_col;
            r_s2_row       <= r_s1_row;
            r_s2_last_row  <= r_s1_last_row;
            r_s2_first_col <= r_s1_first_col;
        end
    end

    // Window ranges: newest two columns, and all three
    logic [7:0] w_max12, w_min12, w_max_all, w_min_all;
    logic [7:0] w_rng12, w_rng_all;

    always_comb begin
        w_max12   = mgr_pkg::max2(mgr_pkg::max3(r_win[3], r_win[4], r_win[5]),
                                  mgr_pkg::max3(r_win[6], r_win[7], r_win[8]));
        w_min12   = mgr_pkg::min2(mgr_pkg::min3(r_win[3], r_win[4], r_win[5]),
                                  mgr_pkg::min3(r_win[6], r_win[7], r_win[8]));
        w_max_all = mgr_pkg::max2(w_max12, mgr_pkg::max3(r_win[0], r_win[1], r_win[2]));
        w_min_all = mgr_pkg::min2(w_min12, mgr_pkg::min3(r_win[0], r_win[1], r_win[2]));
        w_rng12   = 8'(w_max12 - w_min12);
        w_rng_all = 8'(w_max_all - w_min_all);
    end

    // Result pair for the queue
    mgr_pkg::t_push   w_push;
    mgr_pkg::t_result w_res_a, w_res_b, w_head;
    logic [mgr_pkg::CNT_W-1:0] w_count;

    always_comb begin
        w_push.first  = (r_s2_nres != 2'd0);
        w_push.second = (r_s2_nres == 2'd2);

        w_res_a.mirror_column = 10'(w_width - WW'(r_s2_col));
        w_res_a.out_row       = 12'(r_s2_row - 1'b1);
        w_res_a.range_value   = r_s2_first_col ? w_rng12 : w_rng_all;
        w_res_a.run_last      = !w_push.second;
        w_res_a.frame_last    = 1'b0;

        // right border column mirrors to zero
        w_res_b.mirror_column = 10'd0;
        w_res_b.out_row       = 12'(r_s2_row - 1'b1);
        w_res_b.range_value   = w_rng12;
        w_res_b.run_last      = 1'b1;
        w_res_b.frame_last    = r_s2_last_row;
    end

    mgr_ofifo u_ofifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_first  (w_res_a),
        .i_second (w_res_b),
        .i_pop    (i_out_ready),
        .o_valid  (o_out_valid),
        .o_head   (w_head),
        .o_count  (w_count)
    );

    // Accept only if the queue can hold the results of everything in flight
    logic [mgr_pkg::CNT_W:0] w_reserve;

    assign w_reserve  = (mgr_pkg::CNT_W + 1)'(w_count)
                      + (mgr_pkg::CNT_W + 1)'(r_s1_nres)
                      + (mgr_pkg::CNT_W + 1)'(r_s2_nres);
    assign o_in_ready = (w_reserve <= (mgr_pkg::CNT_W + 1)'(mgr_pkg::QDEPTH - 2));

    assign o_mirror_column = w_head.mirror_column;
    assign o_out_row       = w_head.out_row;
    assign o_range_value   = w_head.range_value;
    assign o_run_last      = w_head.run_last;
    assign o_frame_last    = w_head.frame_last;

endmodule

[rtl/core/mgr_check.sv]
// Port-level checks for the gray morphological range block, bound to the top level.
module mgr_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [9:0]  o_mirror_column,
    input logic [11:0] o_out_row,
    input logic [7:0]  o_range_value,
    input logic        o_run_last,
    input logic        o_frame_last
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_mirror_column)
            && $stable(o_out_row) && $stable(o_range_value)
            && $stable(o_run_last) && $stable(o_frame_last))
        else $error("result changed while stalled");

    // Queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Frame end is the right border pixel, which closes its run
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_run_last && (o_mirror_column == 10'd0))
        else $error("frame end not on right border");

    // Only the next-to-last column of a row leaves its run open
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |-> (o_mirror_column == 10'd1) && !o_frame_last)
        else $error("open run on wrong column");

endmodule

bind mirrored_gray_morph_range_3x3 mgr_check u_mgr_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_mirror_column (o_mirror_column),
    .o_out_row       (o_out_row),
    .o_range_value   (o_range_value),
    .o_run_last      (o_run_last),
    .o_frame_last    (o_frame_last)
);

[verif/mirrored_gray_morph_range_3x3_tb.sv]
// Self-checking testbench for the 3x3 gray morphological range block.
module mirrored_gray_morph_range_3x3_tb;

    localparam int MAX_W       = 1024;
    localparam int HALF_PERIOD = 4;
    localparam int SETTLE      = 16;      // cycles for pixels still in the pipe
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1900;
    localparam int BIG_ITEMS   = 30 + MAX_W + 64;
    localparam int PRINT_MAX   = 50;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // DUT signals
    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_blue       = '0;
    logic [7:0]  i_green      = '0;
    logic [7:0]  i_red        = '0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [9:0]  o_mirror_column;
    logic [11:0] o_out_row;
    logic [7:0]  o_range_value;
    logic        o_run_last;
    logic        o_frame_last;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [2:0]  paddr        = '0;
    logic [31:0] pwdata       = '0;
    logic [31:0] prdata;
    logic        pready;

    // Stimulus and scoreboard state
    t_pixel           pixel_q[$];
    mgr_pkg::t_result gradient_q[$];
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          pix_style      = 0;
    int          flat_level     = 0;
    logic        in_took        = 1'b0;
    int          cycle_cnt      = 0;
    int          err_cnt        = 0;
    int          pix_sent       = 0;
    int          res_checked    = 0;
    int          frames_done    = 0;
    int          cfg_writes     = 0;

    // Predictor state
    logic [7:0]  upper_ln[MAX_W];
    logic [7:0]  middle_ln[MAX_W];
    logic [7:0]  win_gray[9];
    int unsigned col_pos;
    int unsigned row_pos;
    logic [10:0] cfg_width;
    logic [11:0] cfg_height;

    mirrored_gray_morph_range_3x3 #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_blue          (i_blue),
        .i_green         (i_green),
        .i_red           (i_red),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_mirror_column (o_mirror_column),
        .o_out_row       (o_out_row),
        .o_range_value   (o_range_value),
        .o_run_last      (o_run_last),
        .o_frame_last    (o_frame_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Clock
    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    // Max minus min of gray over three window columns
    function automatic logic [7:0] win_spread(input int ca, input int cb, input int cd);
        int         cols[3];
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] v;
        cols[0] = ca;
        cols[1] = cb;
        cols[2] = cd;
        hi = 8'd0;
        lo = 8'd255;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                v = win_gray[cols[i] * 3 + j];
                if (v > hi) hi = v;
                if (v < lo) lo = v;
            end
        end
        return hi - lo;
    endfunction

    // Expected results of one accepted pixel, appended to the gradient queue
    function automatic void predict_gradient(input logic [7:0] b, input logic [7:0] g,
                                             input logic [7:0] r);
        int unsigned      w, h, c, rr, y, top, mid, bot;
        mgr_pkg::t_result res;
        logic             tail;
        w = 32'(cfg_width);
        if (w < 2) w = 2;
        if (w > MAX_W) w = MAX_W;
        h = 32'(cfg_height);
        if (h < 2) h = 2;
        c  = col_pos;
        rr = row_pos;
        if (c >= w || rr > h) begin
            c  = 0;
            rr = 0;
        end

        y   = (1868 * int'(b) + 9617 * int'(g) + 4899 * int'(r) + 8192) >> 14;
        mid = 32'(middle_ln[c]);
        top = (rr <= 1) ? mid : 32'(upper_ln[c]);
        bot = (rr == h) ? mid : y;

        for (int k = 0; k < 6; k++) win_gray[k] = win_gray[k + 3];
        win_gray[6] = top[7:0];
        win_gray[7] = mid[7:0];
        win_gray[8] = bot[7:0];

        // one result per pixel, a row and a column behind; none in row or column zero, two at row end
        if (rr >= 1 && c >= 1) begin
            tail              = (c == w - 1);
            res.mirror_column = 10'(w - c);
            res.out_row       = 12'(rr - 1);
            res.range_value   = (c == 1) ? win_spread(1, 1, 2) : win_spread(0, 1, 2);
            res.run_last      = !tail;
            res.frame_last    = 1'b0;
            gradient_q.insert(gradient_q.size(), res);
            if (tail) begin
                res.mirror_column = 10'd0;
                res.range_value   = win_spread(1, 2, 2);
                res.run_last      = 1'b1;
                res.frame_last    = (rr == h);
                gradient_q.insert(gradient_q.size(), res);
            end
        end

        if (rr < h) begin
            upper_ln[c]  = middle_ln[c];
            middle_ln[c] = y[7:0];
        end

        c++;
        if (c >= w) begin
            c = 0;
            rr++;
            if (rr > h) rr = 0;
        end
        col_pos = c;
        row_pos = rr;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < PRINT_MAX)
            $display("cycle %0d: %s mismatch, got %0d expected %0d", cycle_cnt, what, got, want);
        err_cnt++;
    endtask

    // Pixel driver: holds a transaction until accepted, gaps at random
    always @(negedge i_clk) begin : pixel_drv
        logic   nv;
        t_pixel nxt;
        nv = i_in_valid;
        if (in_took) nv = 1'b0;
        if (!nv && i_rst_n && pixel_q.size() > 0 &&
            $urandom_range(99) >= send_idle_pct) begin
            nxt = pixel_q.pop_front();
            i_blue  <= nxt.blue;
            i_green <= nxt.green;
            i_red   <= nxt.red;
            nv = 1'b1;
        end
        i_in_valid  <= nv;
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: predict on accepted pixels, check accepted results
    always @(posedge i_clk) begin : result_mon
        mgr_pkg::t_result want;
        cycle_cnt++;
        in_took = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_gradient(i_blue, i_green, i_red);
                in_took = 1'b1;
                pix_sent++;
            end
            if (o_out_valid && i_out_ready) begin
                if (gradient_q.size() == 0) begin
                    report_mismatch("unexpected result, column", int'(o_mirror_column), -1);
                end else begin
                    want = gradient_q.pop_front();
                    if (o_mirror_column != want.mirror_column)
                        report_mismatch("mirror_column", int'(o_mirror_column),
                                        int'(want.mirror_column));
                    if (o_out_row != want.out_row)
                        report_mismatch("out_row", int'(o_out_row), int'(want.out_row));
                    if (o_range_value != want.range_value)
                        report_mismatch("range_value", int'(o_range_value),
                                        int'(want.range_value));
                    if (o_run_last != want.run_last)
                        report_mismatch("run_last", int'(o_run_last), int'(want.run_last));
                    if (o_frame_last != want.frame_last)
                        report_mismatch("frame_last", int'(o_frame_last),
                                        int'(want.frame_last));
                    res_checked++;
                    if (want.frame_last) frames_done++;
                end
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, gradient_q.size());
            $display("** mirrored_gray_morph_range_3x3: FAILED **");
            $finish;
        end
    end

    // Register write over the APB port; predictor follows once written
    task automatic cfg_write(input logic idx, input int unsigned value);
        logic [31:0] wdata;
        wdata = value;
        if ($urandom_range(1)) wdata = wdata | ($urandom() << 12);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == mgr_pkg::REG_FRAME_WIDTH) cfg_width = wdata[10:0];
        else cfg_height = wdata[11:0];
        col_pos = 0;
        row_pos = 0;
        cfg_writes++;
    endtask

    // Wait until every pixel went in and every expected result came out
    task automatic wait_quiet();
        while (pixel_q.size() != 0 || i_in_valid || gradient_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void push_px(input int b, input int g, input int r);
        t_pixel p;
        p.blue  = b[7:0];
        p.green = g[7:0];
        p.red   = r[7:0];
        pixel_q.insert(pixel_q.size(), p);
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        case (pix_style)
            1: begin
                p.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
                p.green = $urandom_range(1) ? 8'd255 : 8'd0;
                p.red   = $urandom_range(1) ? 8'd255 : 8'd0;
            end
            2: begin
                // nearly flat area, small ranges
                p.blue  = 8'(flat_level + $urandom_range(4));
                p.green = 8'(flat_level + $urandom_range(4));
                p.red   = 8'(flat_level + $urandom_range(4));
            end
            default: begin
                p.blue  = 8'($urandom_range(255));
                p.green = 8'($urandom_range(255));
                p.red   = 8'($urandom_range(255));
            end
        endcase
        return p;
    endfunction

    function automatic void queue_pixels(input int n);
        for (int i = 0; i < n; i++) pixel_q.insert(pixel_q.size(), rand_pixel());
    endfunction

    function automatic void set_idling(input int k);
        case (k % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endfunction

    // Main sequence
    initial begin
        int  rand_items;
        int  phase_idx;
        int  wv, hv, ew, eh, nfr, n, half, lim;
        bit  big_done;
        bit  paused_once;

        for (int i = 0; i < MAX_W; i++) begin
            upper_ln[i]  = 8'd0;
            middle_ln[i] = 8'd0;
        end
        for (int i = 0; i < 9; i++) win_gray[i] = 8'd0;
        col_pos     = 0;
        row_pos     = 0;
        cfg_width   = mgr_pkg::FRAME_WIDTH_RST;
        cfg_height  = mgr_pkg::FRAME_HEIGHT_RST;
        rand_items  = 0;
        phase_idx   = 0;
        big_done    = 1'b0;
        paused_once = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // 3x2 frame with channel extremes, then its drain row
        cfg_write(mgr_pkg::REG_FRAME_WIDTH, 3);
        cfg_write(mgr_pkg::REG_FRAME_HEIGHT, 2);
        push_px(0, 0, 0);     push_px(255, 255, 255); push_px(255, 0, 0);
        push_px(0, 255, 0);   push_px(0, 0, 255);     push_px(255, 255, 255);
        push_px(0, 0, 0);     push_px(17, 200, 90);   push_px(255, 255, 255);
        wait_quiet();

        // width and height below range clamp to 2x2
        cfg_write(mgr_pkg::REG_FRAME_WIDTH, 1);
        cfg_write(mgr_pkg::REG_FRAME_HEIGHT, 0);
        push_px(255, 255, 255); push_px(0, 0, 0);
        push_px(0, 0, 0);       push_px(255, 255, 255);
        push_px(128, 128, 128); push_px(0, 0, 0);
        wait_quiet();

        // partial frame, cut short by the next write
        cfg_write(mgr_pkg::REG_FRAME_WIDTH, 5);
        cfg_write(mgr_pkg::REG_FRAME_HEIGHT, 3);
        queue_pixels(7);
        wait_quiet();

        // random frames
        while (rand_items < RAND_ITEMS) begin
            set_idling(phase_idx);
            phase_idx++;
            pix_style  = $urandom_range(2);
            flat_level = $urandom_range(250);

            if (!big_done && rand_items > 400) begin
                // width above range saturates; only part of the first row goes in
                cfg_write(mgr_pkg::REG_FRAME_WIDTH, 2047);
                queue_pixels(30);
                rand_items += 30;
                wait_quiet();
                // widest row and tallest frame, first rows only
                cfg_write(mgr_pkg::REG_FRAME_WIDTH, MAX_W);
                cfg_write(mgr_pkg::REG_FRAME_HEIGHT, 4095);
                queue_pixels(MAX_W + 64);
                rand_items += MAX_W + 64;
                big_done = 1'b1;
                wait_quiet();
            end else begin
                wv = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(2, 12);
                hv = $urandom_range(2, 6);
                if ($urandom_range(11) == 0) wv = $urandom_range(1);
                if ($urandom_range(11) == 0) hv = $urandom_range(1);
                ew  = (wv < 2) ? 2 : wv;
                eh  = (hv < 2) ? 2 : hv;
                nfr = $urandom_range(1, 3);
                n   = ew * (eh + 1) * nfr;
                // broken sequence: frame cut short
                if ($urandom_range(7) == 0) n = n - $urandom_range(1, ew * 2);
                // keep the total near the item budget
                lim = big_done ? RAND_ITEMS : RAND_ITEMS - BIG_ITEMS;
                if (rand_items + n > lim) n = lim - rand_items;

                if ($urandom_range(1)) begin
                    cfg_write(mgr_pkg::REG_FRAME_WIDTH, wv);
                    cfg_write(mgr_pkg::REG_FRAME_HEIGHT, hv);
                end else begin
                    cfg_write(mgr_pkg::REG_FRAME_HEIGHT, hv);
                    cfg_write(mgr_pkg::REG_FRAME_WIDTH, wv);
                end

                if (!paused_once || $urandom_range(5) == 0) begin
                    // sender holds mid-frame until all results are out
                    half = n / 2;
                    queue_pixels(half);
                    wait_quiet();
                    queue_pixels(n - half);
                    paused_once = 1'b1;
                end else begin
                    queue_pixels(n);
                end
                rand_items += n;
                wait_quiet();
            end
        end

        wait_quiet();
        $display("covered %0d pixels, %0d results checked, %0d full frames, %0d register writes",
                 pix_sent, res_checked, frames_done, cfg_writes);
        $display("widths 2 to 1024 and heights 2 to 4095 incl. clamped values, mixed stalls");
        if (err_cnt == 0) begin
            $display("** mirrored_gray_morph_range_3x3: PASSED **");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("** mirrored_gray_morph_range_3x3: FAILED **");
        end
        $finish;
    end

endmodule
